@@ rtl/apn_pkg.sv @@
package apn_pkg;

  localparam int PATH_BYTES = 64;
  localparam int LEN_W = $clog2(PATH_BYTES + 1);
  localparam int IDX_W = $clog2(PATH_BYTES);

  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_PATH = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  localparam logic [1:0] HELD_TWO = 2'd2;

  typedef enum logic [1:0] {
    PUT_SLASH,
    PUT_DOT,
    PUT_CUR
  } put_sel_t;

  typedef struct packed {
    logic     load;
    logic     mark_seen;
    logic     first_byte;
    logic     set_path_err;
    logic     hold_dot;
    logic     clear_pending;
    logic     put;
    put_sel_t put_sel;
    logic     open_comp;
    logic     pop_start;
    logic     pop_step;
    logic     pop_end;
    logic     out_start;
    logic     out_emit;
    logic     out_err;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic       zero;
    logic       cur_slash;
    logic       cur_dot;
    logic       started;
    logic       err_any;
    logic       open;
    logic [1:0] held;
    logic       len_gt1;
    logic       len_zero;
    logic       scan_hit;
    logic       last;
  } status_t;

endpackage

@@ rtl/apn_datapath.sv @@
module apn_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      path_byte,
  input  apn_pkg::cmd_t   cmd,
  output apn_pkg::status_t st,
  output logic            strobe,
  output logic [7:0]      result_byte,
  output logic            final_byte,
  output logic [1:0]      outcome
);
  import apn_pkg::*;

  logic [7:0]       mem [PATH_BYTES];
  logic [7:0]       cur_byte;
  logic [LEN_W-1:0] len;
  logic             open;
  logic [1:0]       held;
  logic             started;
  logic [1:0]       err;
  logic [IDX_W-1:0] scan;
  logic [IDX_W-1:0] scan_next;
  logic [7:0]       rdata;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [7:0]       put_byte;
  logic             put_ok;

  always_comb begin
    case (cmd.put_sel)
      PUT_SLASH: put_byte = SLASH_CHAR;
      PUT_DOT:   put_byte = DOT_CHAR;
      default:   put_byte = cur_byte;
    endcase
  end

  assign put_ok = cmd.put && (err == ERR_NONE) && (len < LEN_W'(PATH_BYTES));

  always_comb begin
    wr_en = 1'b0;
    wr_addr = len[IDX_W-1:0];
    wr_data = put_byte;
    if (cmd.first_byte && cur_byte == SLASH_CHAR) begin
      wr_en = 1'b1;
      wr_addr = '0;
      wr_data = SLASH_CHAR;
    end else if (put_ok) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    scan_next = scan;
    if (cmd.pop_start) begin
      scan_next = IDX_W'(len - LEN_W'(1));
    end else if (cmd.pop_step) begin
      scan_next = scan - IDX_W'(1);
    end else if (cmd.out_start) begin
      scan_next = '0;
    end else if (cmd.out_emit) begin
      scan_next = scan + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[scan_next];
    scan <= scan_next;
    if (cmd.load) begin
      cur_byte <= path_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      open <= 1'b0;
      held <= '0;
      started <= 1'b0;
      err <= ERR_NONE;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.out_emit || cmd.out_err;
      if (cmd.mark_seen) begin
        started <= 1'b1;
      end
      if (cmd.first_byte) begin
        if (cur_byte == SLASH_CHAR) begin
          len <= LEN_W'(1);
          open <= 1'b0;
          held <= '0;
        end else begin
          err <= ERR_PATH;
        end
      end
      if (cmd.set_path_err) begin
        err <= ERR_PATH;
      end
      if (cmd.hold_dot) begin
        held <= held + 2'd1;
      end
      if (cmd.clear_pending) begin
        open <= 1'b0;
        held <= '0;
      end
      if (cmd.put && err == ERR_NONE) begin
        if (put_ok) begin
          len <= len + LEN_W'(1);
        end else begin
          err <= ERR_OVERFLOW;
        end
      end
      if (cmd.open_comp) begin
        open <= 1'b1;
        held <= '0;
      end
      if (cmd.pop_end) begin
        len <= (scan != '0) ? LEN_W'(scan) : LEN_W'(1);
        open <= 1'b0;
        held <= '0;
      end
      if (cmd.finish) begin
        len <= '0;
        open <= 1'b0;
        held <= '0;
        started <= 1'b0;
        err <= ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_err) begin
      result_byte <= NUL_CHAR;
      final_byte <= 1'b1;
      outcome <= (err != ERR_NONE) ? err : ERR_PATH;
    end else if (cmd.out_emit) begin
      result_byte <= rdata;
      final_byte <= st.last;
      outcome <= ERR_NONE;
    end
  end

  assign st.zero = (cur_byte == NUL_CHAR);
  assign st.cur_slash = (cur_byte == SLASH_CHAR);
  assign st.cur_dot = (cur_byte == DOT_CHAR);
  assign st.started = started;
  assign st.err_any = (err != ERR_NONE);
  assign st.open = open;
  assign st.held = held;
  assign st.len_gt1 = (len > LEN_W'(1));
  assign st.len_zero = (len == '0);
  assign st.scan_hit = (scan == '0) || (rdata == SLASH_CHAR);
  assign st.last = ((LEN_W'(scan) + LEN_W'(1)) == len);

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(PATH_BYTES))
    else $error("stored length beyond buffer");

  a_open_no_held: assert property (@(posedge clk) disable iff (rst)
    open |-> (held == '0))
    else $error("held dots inside an open component");

  a_err_final: assert property (@(posedge clk) disable iff (rst)
    (strobe && outcome != ERR_NONE) |-> final_byte)
    else $error("failure transfer not marked final");

  a_last_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_emit && st.last) |=> (strobe && final_byte))
    else $error("last byte transfer lost its final mark");

endmodule

@@ rtl/apn_controller.sv @@
module apn_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  apn_pkg::status_t st,
  output apn_pkg::cmd_t    cmd,
  output logic             busy
);
  import apn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DOT_A,
    S_DOT_B,
    S_PUT_CUR,
    S_POP_CHK,
    S_OUT_DECIDE,
    S_OUT_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    cmd.put_sel = PUT_CUR;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.zero) begin
          state_next = S_OUT_DECIDE;
          if (!st.started && !st.err_any) begin
            cmd.set_path_err = 1'b1;
          end else if (!st.err_any && !st.open && st.held == HELD_TWO) begin
            if (!st.len_gt1) begin
              cmd.set_path_err = 1'b1;
              cmd.clear_pending = 1'b1;
            end else begin
              cmd.pop_start = 1'b1;
              state_next = S_POP_CHK;
            end
          end
        end else begin
          cmd.mark_seen = 1'b1;
          state_next = S_IDLE;
          if (!st.started) begin
            cmd.first_byte = 1'b1;
          end else if (st.err_any) begin
            state_next = S_IDLE;
          end else if (st.cur_slash) begin
            if (!st.open && st.held == HELD_TWO) begin
              if (!st.len_gt1) begin
                cmd.set_path_err = 1'b1;
                cmd.clear_pending = 1'b1;
              end else begin
                cmd.pop_start = 1'b1;
                state_next = S_POP_CHK;
              end
            end else begin
              cmd.clear_pending = 1'b1;
            end
          end else if (st.cur_dot && !st.open && st.held < HELD_TWO) begin
            cmd.hold_dot = 1'b1;
          end else if (st.open) begin
            cmd.put = 1'b1;
          end else begin
            cmd.put = st.len_gt1;
            cmd.put_sel = PUT_SLASH;
            state_next = (st.held != '0) ? S_DOT_A : S_PUT_CUR;
          end
        end
      end
      S_DOT_A: begin
        cmd.put = 1'b1;
        cmd.put_sel = PUT_DOT;
        state_next = (st.held == HELD_TWO) ? S_DOT_B : S_PUT_CUR;
      end
      S_DOT_B: begin
        cmd.put = 1'b1;
        cmd.put_sel = PUT_DOT;
        state_next = S_PUT_CUR;
      end
      S_PUT_CUR: begin
        cmd.put = 1'b1;
        cmd.open_comp = 1'b1;
        state_next = S_IDLE;
      end
      S_POP_CHK: begin
        if (st.scan_hit) begin
          cmd.pop_end = 1'b1;
          state_next = st.zero ? S_OUT_DECIDE : S_IDLE;
        end else begin
          cmd.pop_step = 1'b1;
        end
      end
      S_OUT_DECIDE: begin
        if (st.err_any || st.len_zero) begin
          cmd.out_err = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.out_start = 1'b1;
          state_next = S_OUT_EMIT;
        end
      end
      S_OUT_EMIT: begin
        cmd.out_emit = 1'b1;
        if (st.last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted without going busy");

  a_pop_guard: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_start |-> (st.len_gt1 && !st.open))
    else $error("pop started on root or open component");

  a_put_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.put || cmd.out_emit) |-> busy)
    else $error("datapath command while idle");

endmodule

@@ rtl/absolute_path_normalizer.sv @@
// Non-zero byte: busy from the transfer until the next accept; a component that opens
// stores the separator (none at the root), any held dots and the byte in turn; a
// double-dot scans back over the stored bytes (up to 64). Zero byte: results follow any
// double-dot scan, one result per cycle, busy until the last result is registered.
// Reset (rst, synchronous): idle, empty path, no pending result; store contents undefined.
module absolute_path_normalizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] path_byte,
  output logic       strobe,
  output logic [7:0] result_byte,
  output logic       final_byte,
  output logic [1:0] outcome
);
  import apn_pkg::*;

  cmd_t    cmd;
  status_t st;

  apn_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  apn_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .path_byte   (path_byte),
    .cmd         (cmd),
    .st          (st),
    .strobe      (strobe),
    .result_byte (result_byte),
    .final_byte  (final_byte),
    .outcome     (outcome)
  );

endmodule

@@ dv/absolute_path_normalizer_test.sv @@
module absolute_path_normalizer_test;
  import apn_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 120;

  typedef struct {
    logic [7:0]  value;
    int unsigned idle_pct;
    bit          drain;
  } path_item_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic [1:0] status;
  } norm_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] path_byte = '0;
  logic       busy;
  logic       strobe;
  logic [7:0] result_byte;
  logic       final_byte;
  logic [1:0] outcome;

  path_item_t  pending_q[$];
  norm_byte_t  normalized_q[$];
  int unsigned fails = 0;
  int unsigned quiet_cycles = 0;

  logic [7:0]       path_copy [PATH_BYTES];
  logic [LEN_W-1:0] path_len = '0;
  logic [1:0]       held_dots = '0;
  logic             comp_open = 1'b0;
  logic [6:0]       seen_cnt = '0;
  logic [1:0]       path_err = ERR_NONE;

  absolute_path_normalizer i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .path_byte   (path_byte),
    .strobe      (strobe),
    .result_byte (result_byte),
    .final_byte  (final_byte),
    .outcome     (outcome)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void store_byte(logic [7:0] b);
    if (path_err == ERR_NONE) begin
      if (path_len >= PATH_BYTES) begin
        path_err = ERR_OVERFLOW;
      end else begin
        path_copy[path_len[IDX_W-1:0]] = b;
        path_len = path_len + 1'b1;
      end
    end
  endfunction

  function automatic void close_component();
    int p;
    if (!comp_open && held_dots == HELD_TWO) begin
      if (path_len <= 1) begin
        path_err = ERR_PATH;
      end else begin
        p = int'(path_len) - 1;
        while (p > 0 && path_copy[p] != SLASH_CHAR) p--;
        path_len = (p > 0) ? LEN_W'(p) : LEN_W'(1);
      end
    end
    held_dots = 2'd0;
    comp_open = 1'b0;
  endfunction

  function automatic void normalize_byte(logic [7:0] b);
    norm_byte_t r;
    if (b == NUL_CHAR) begin
      if (seen_cnt == 0 && path_err == ERR_NONE) path_err = ERR_PATH;
      else if (path_err == ERR_NONE) close_component();
      if (path_err != ERR_NONE || path_len == 0) begin
        r.value  = NUL_CHAR;
        r.last   = 1'b1;
        r.status = (path_err != ERR_NONE) ? path_err : ERR_PATH;
        normalized_q.push_back(r);
      end else begin
        for (int k = 0; k < int'(path_len); k++) begin
          r.value  = path_copy[k];
          r.last   = (k + 1 == int'(path_len));
          r.status = ERR_NONE;
          normalized_q.push_back(r);
        end
      end
      path_len  = '0;
      held_dots = '0;
      comp_open = 1'b0;
      seen_cnt  = '0;
      path_err  = ERR_NONE;
    end else begin
      if (seen_cnt == 0) begin
        if (b != SLASH_CHAR) begin
          path_err = ERR_PATH;
        end else begin
          path_copy[0] = SLASH_CHAR;
          path_len     = LEN_W'(1);
          held_dots    = '0;
          comp_open    = 1'b0;
        end
      end else if (path_err == ERR_NONE) begin
        if (b == SLASH_CHAR) begin
          close_component();
        end else if (b == DOT_CHAR && !comp_open && held_dots < HELD_TWO) begin
          held_dots++;
        end else begin
          if (!comp_open) begin
            if (path_len > 1) store_byte(SLASH_CHAR);
            for (int k = 0; k < int'(held_dots); k++) store_byte(DOT_CHAR);
            held_dots = '0;
            comp_open = 1'b1;
          end
          store_byte(b);
        end
      end
      if (seen_cnt != 7'd127) seen_cnt++;
    end
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] v;
    if ($urandom_range(3) == 0) begin
      v = DOT_CHAR;
    end else begin
      v = 8'($urandom_range(1, 255));
      while (v == SLASH_CHAR) v = 8'($urandom_range(1, 255));
    end
    return v;
  endfunction

  task automatic queue_bytes(logic [7:0] txt[$], int unsigned idle_pct, bit drain);
    path_item_t it;
    for (int i = 0; i <= txt.size(); i++) begin
      it.value    = (i < txt.size()) ? txt[i] : NUL_CHAR;
      it.idle_pct = idle_pct;
      it.drain    = drain && (i == 0);
      pending_q.push_back(it);
    end
  endtask

  task automatic queue_text(string s, int unsigned idle_pct, bit drain);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    queue_bytes(txt, idle_pct, drain);
  endtask

  task automatic queue_random_path(int unsigned idle_pct, bit drain);
    logic [7:0]  txt[$];
    bit          long_path;
    int unsigned comps;
    int unsigned sel;
    int unsigned len;
    long_path = ($urandom_range(99) < 8);
    comps = long_path ? $urandom_range(4, 8) : $urandom_range(0, 5);
    if ($urandom_range(99) < 6) begin
      txt.push_back(name_byte() == DOT_CHAR ? DOT_CHAR : 8'($urandom_range(1, 255)));
      if (txt[0] == SLASH_CHAR) txt[0] = 8'hFF;
    end else begin
      txt.push_back(SLASH_CHAR);
    end
    for (int c = 0; c < int'(comps); c++) begin
      if (c > 0) txt.push_back(SLASH_CHAR);
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 2)) txt.push_back(SLASH_CHAR);
      end
      sel = $urandom_range(9);
      case (sel)
        0: txt.push_back(DOT_CHAR);
        1, 2: begin
          txt.push_back(DOT_CHAR);
          txt.push_back(DOT_CHAR);
        end
        3: repeat (3) txt.push_back(DOT_CHAR);
        4: begin
          txt.push_back(DOT_CHAR);
          txt.push_back(name_byte());
        end
        default: begin
          len = long_path ? $urandom_range(8, 20) : $urandom_range(1, 4);
          repeat (len) txt.push_back(name_byte());
        end
      endcase
    end
    if ($urandom_range(4) == 0) txt.push_back(SLASH_CHAR);
    queue_bytes(txt, idle_pct, drain);
  endtask

  always @(posedge clk) begin : drive
    logic       take;
    path_item_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) normalize_byte(path_byte);
      if (start && !take) begin
        // hold until the transfer
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && normalized_q.size() != 0) &&
                   $urandom_range(99) >= pending_q[0].idle_pct) begin
        nxt = pending_q.pop_front();
        start     <= 1'b1;
        path_byte <= nxt.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    norm_byte_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (strobe) begin
        if (normalized_q.size() == 0) begin
          $display("%0t: unexpected result: byte %h final %b outcome %0d",
                   $time, result_byte, final_byte, outcome);
          fails++;
        end else begin
          want = normalized_q.pop_front();
          if (result_byte !== want.value) begin
            $display("%0t: result_byte expected %h got %h", $time, want.value, result_byte);
            fails++;
          end
          if (final_byte !== want.last) begin
            $display("%0t: final_byte expected %b got %b", $time, want.last, final_byte);
            fails++;
          end
          if (outcome !== want.status) begin
            $display("%0t: outcome expected %0d got %0d", $time, want.status, outcome);
            fails++;
          end
        end
      end
      if (strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run
    int unsigned mark;
    int unsigned idle_set [4];
    idle_set = '{0, 88, 7, 0};
    queue_text("", 0, 1'b0);
    queue_text("\377/", 0, 1'b0);
    queue_text("/..", 0, 1'b0);
    queue_text("/", 0, 1'b0);
    queue_text("/.a/.../b/./../", 0, 1'b0);
    foreach (idle_set[ph]) begin
      mark = pending_q.size();
      queue_random_path(idle_set[ph], 1'b1);
      while (pending_q.size() < mark + PHASE_ITEMS) queue_random_path(idle_set[ph], 1'b0);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() != 0 || start || normalized_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/apn_pkg.sv
rtl/apn_datapath.sv
rtl/apn_controller.sv
rtl/absolute_path_normalizer.sv
dv/absolute_path_normalizer_test.sv
